[hdl/wmar_pkg.sv]
// ----------------------------------------------------------------------------
// wmar_pkg
// Shared widths, flag bundle and back-end state type for the row smoother.
// ----------------------------------------------------------------------------
package wmar_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int HW_W        = 5;
    localparam int SMOOTH_W    = 24;
    localparam int SCALE_SHIFT = 7;

    typedef struct packed {
        logic row_last;
        logic run_last;
    } t_out_flags;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ACC,
        BK_LAST,
        BK_DIV
    } t_back_state;

endpackage

[hdl/wmar_ram.sv]
// ----------------------------------------------------------------------------
// wmar_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module wmar_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/wmar_fifo.sv]
// ----------------------------------------------------------------------------
// wmar_fifo
// Small command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module wmar_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_push_ready,
    output logic             o_pop_valid,
    output logic [WIDTH-1:0] o_pop_data,
    input  logic             i_pop_ready
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CNTW-1:0]  r_fill, n_fill;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_fill != CNTW'(DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr   = r_wr;
        n_rd   = r_rd;
        n_fill = r_fill;
        if (push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (push && !pop) begin
            n_fill = r_fill + CNTW'(1);
        end else if (pop && !push) begin
            n_fill = r_fill - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

[hdl/wmar_front.sv]
// ----------------------------------------------------------------------------
// wmar_front
// Accept samples, store them in the ring buffer and classify each beat into
// a back-end command (center offset, window, row count, row end).
// ----------------------------------------------------------------------------
module wmar_front #(
    parameter int MAX_HALF_WIDTH = 16,
    parameter int RAM_AW         = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [wmar_pkg::HW_W-1:0]    i_cfg_half_width,
    input  logic                         i_valid,
    input  logic [wmar_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                         i_row_end,
    output logic                         o_ready,
    input  logic                         i_push_ready,
    output logic                         o_push_valid,
    output logic [2 + RAM_AW + 2 * $clog2(MAX_HALF_WIDTH + 1)
                  + $clog2(2 * MAX_HALF_WIDTH + 2) - 1:0] o_cmd,
    output logic                         o_we,
    output logic [RAM_AW-1:0]            o_waddr,
    output logic [wmar_pkg::SAMPLE_W-1:0] o_wdata
);

    localparam int NW    = $clog2(MAX_HALF_WIDTH + 1);
    localparam int CW    = $clog2(2 * MAX_HALF_WIDTH + 2);
    localparam int STORE = 2 * MAX_HALF_WIDTH + 1;

    logic [wmar_pkg::HW_W-1:0] r_half_width;
    logic [RAM_AW-1:0]         r_wp, n_wp;
    logic [CW-1:0]             r_cnt, n_cnt;
    logic [NW-1:0]             n_eff;
    logic [CW-1:0]             cnt_inc;
    logic [CW-1:0]             m_out;
    logic                      has_out;
    logic [NW-1:0]             j0;
    logic                      accept;

    assign o_ready      = i_push_ready;
    assign o_push_valid = i_valid;
    assign accept       = i_valid && i_push_ready;
    assign o_we         = accept;
    assign o_waddr      = r_wp;
    assign o_wdata      = i_sample;

    always_comb begin
        if (int'(r_half_width) > MAX_HALF_WIDTH) begin
            n_eff = NW'(MAX_HALF_WIDTH);
        end else begin
            n_eff = NW'(r_half_width);
        end
        cnt_inc = (r_cnt < CW'(STORE)) ? r_cnt + CW'(1) : r_cnt;
        m_out   = (cnt_inc < CW'(n_eff) + CW'(1)) ? cnt_inc : CW'(n_eff) + CW'(1);
        if (i_row_end) begin
            has_out = 1'b1;
            j0      = NW'(m_out - CW'(1));
        end else begin
            has_out = (cnt_inc > CW'(n_eff));
            j0      = n_eff;
        end
        o_cmd = {has_out, i_row_end, r_wp, n_eff, cnt_inc, j0};
        n_wp  = r_wp;
        n_cnt = r_cnt;
        if (accept) begin
            n_wp  = r_wp + RAM_AW'(1);
            n_cnt = i_row_end ? '0 : cnt_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width <= '0;
            r_wp         <= '0;
            r_cnt        <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_half_width <= i_cfg_half_width;
            end
            r_wp  <= n_wp;
            r_cnt <= n_cnt;
        end
    end

endmodule

[hdl/wmar_div.sv]
// ----------------------------------------------------------------------------
// wmar_div
// Radix-2 restoring divider: (sum << 7) / (n + 1), one quotient bit a cycle,
// followed by the output register of the block.
// ----------------------------------------------------------------------------
module wmar_div #(
    parameter int SUM_W = 22,
    parameter int DVW   = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [SUM_W-1:0]              i_sum,
    input  logic [DVW-1:0]                i_divisor,
    input  wmar_pkg::t_out_flags          i_flags,
    output logic                          o_in_ready,
    output logic                          o_valid,
    output logic [wmar_pkg::SMOOTH_W-1:0] o_smoothed,
    output wmar_pkg::t_out_flags          o_flags,
    input  logic                          i_ready
);

    localparam int DW   = SUM_W + wmar_pkg::SCALE_SHIFT;
    localparam int CNTW = $clog2(DW + 1);

    logic                          r_busy, n_busy;
    logic [CNTW-1:0]               r_cnt, n_cnt;
    logic [DVW-1:0]                r_rem, n_rem;
    logic [DW-1:0]                 r_quo, n_quo;
    logic [DVW-1:0]                r_dvs, n_dvs;
    wmar_pkg::t_out_flags          r_flags, n_flags;
    logic                          r_ovld, n_ovld;
    logic [wmar_pkg::SMOOTH_W-1:0] r_osm, n_osm;
    wmar_pkg::t_out_flags          r_oflags, n_oflags;
    logic [DVW:0]                  trial;
    logic                          ge;

    assign o_in_ready = !r_busy;
    assign o_valid    = r_ovld;
    assign o_smoothed = r_osm;
    assign o_flags    = r_oflags;

    always_comb begin
        trial    = {r_rem, r_quo[DW-1]};
        ge       = (trial >= {1'b0, r_dvs});
        n_busy   = r_busy;
        n_cnt    = r_cnt;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_dvs    = r_dvs;
        n_flags  = r_flags;
        n_ovld   = r_ovld;
        n_osm    = r_osm;
        n_oflags = r_oflags;
        if (r_ovld && i_ready) begin
            n_ovld = 1'b0;
        end
        if (!r_busy) begin
            if (i_valid) begin
                n_busy  = 1'b1;
                n_cnt   = CNTW'(DW);
                n_rem   = '0;
                n_quo   = {i_sum, {wmar_pkg::SCALE_SHIFT{1'b0}}};
                n_dvs   = i_divisor;
                n_flags = i_flags;
            end
        end else if (r_cnt != '0) begin
            n_rem = ge ? DVW'(trial - {1'b0, r_dvs}) : trial[DVW-1:0];
            n_quo = {r_quo[DW-2:0], ge};
            n_cnt = r_cnt - CNTW'(1);
        end else if (!r_ovld || i_ready) begin
            n_busy   = 1'b0;
            n_ovld   = 1'b1;
            n_osm    = wmar_pkg::SMOOTH_W'(r_quo);
            n_oflags = r_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_ovld <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_dvs    <= n_dvs;
        r_flags  <= n_flags;
        r_osm    <= n_osm;
        r_oflags <= n_oflags;
    end

endmodule

[hdl/wmar_back.sv]
// ----------------------------------------------------------------------------
// wmar_back
// Pop commands, walk the window one ring-buffer read a cycle to build the
// weighted sum, and hand each sum to the divider.
// ----------------------------------------------------------------------------
module wmar_back #(
    parameter int MAX_HALF_WIDTH = 16,
    parameter int RAM_AW         = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  logic [2 + RAM_AW + 2 * $clog2(MAX_HALF_WIDTH + 1)
                  + $clog2(2 * MAX_HALF_WIDTH + 2) - 1:0] i_cmd,
    output logic                          o_cmd_pop,
    output logic [RAM_AW-1:0]             o_raddr,
    input  logic [wmar_pkg::SAMPLE_W-1:0] i_rdata,
    output logic                          o_div_valid,
    input  logic                          i_div_ready,
    output logic [$clog2(2 * MAX_HALF_WIDTH + 2) + wmar_pkg::SAMPLE_W - 1:0] o_sum,
    output logic [$clog2(MAX_HALF_WIDTH + 2)-1:0] o_divisor,
    output wmar_pkg::t_out_flags          o_flags
);

    localparam int NW    = $clog2(MAX_HALF_WIDTH + 1);
    localparam int CW    = $clog2(2 * MAX_HALF_WIDTH + 2);
    localparam int OW    = $clog2(2 * MAX_HALF_WIDTH + 1);
    localparam int TW    = OW + 1;
    localparam int SUM_W = CW + wmar_pkg::SAMPLE_W;
    localparam int DVW   = $clog2(MAX_HALF_WIDTH + 2);

    wmar_pkg::t_back_state r_state, n_state;
    logic [RAM_AW-1:0]     r_wp, n_wp;
    logic [NW-1:0]         r_n, n_n;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [NW-1:0]         r_j, n_j;
    logic                  r_end, n_end;
    logic [CW-1:0]         r_step, n_step;
    logic [SUM_W-1:0]      r_sum, n_sum;
    logic                  r_rd_vld, n_rd_vld;

    logic                  c_has_out;
    logic                  c_row_end;
    logic [RAM_AW-1:0]     c_wp;
    logic [NW-1:0]         c_n;
    logic [CW-1:0]         c_cnt;
    logic [NW-1:0]         c_j0;
    logic [TW-1:0]         t_pos;
    logic                  pos_ok;
    logic [OW-1:0]         off;
    logic                  last_step;
    logic                  last_out;

    assign {c_has_out, c_row_end, c_wp, c_n, c_cnt, c_j0} = i_cmd;

    always_comb begin
        t_pos     = TW'(r_j) + TW'(r_step) - TW'(1);
        pos_ok    = (t_pos >= TW'(r_n)) && (t_pos < TW'(r_cnt) + TW'(r_n));
        off       = (r_step != '0 && pos_ok) ? OW'(t_pos - TW'(r_n)) : OW'(r_j);
        last_step = (r_step == CW'({r_n, 1'b1}));
        last_out  = (r_j == '0) || !r_end;
    end

    assign o_raddr          = r_wp - RAM_AW'(off);
    assign o_sum            = r_sum;
    assign o_divisor        = DVW'(r_n) + DVW'(1);
    assign o_flags.row_last = r_end && (r_j == '0);
    assign o_flags.run_last = last_out;

    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_n         = r_n;
        n_cnt       = r_cnt;
        n_j         = r_j;
        n_end       = r_end;
        n_step      = r_step;
        n_sum       = r_rd_vld ? r_sum + SUM_W'(i_rdata) : r_sum;
        n_rd_vld    = 1'b0;
        o_cmd_pop   = 1'b0;
        o_div_valid = 1'b0;
        case (r_state)
            wmar_pkg::BK_IDLE: begin
                o_cmd_pop = i_cmd_valid;
                if (i_cmd_valid && c_has_out) begin
                    n_wp    = c_wp;
                    n_n     = c_n;
                    n_cnt   = c_cnt;
                    n_j     = c_j0;
                    n_end   = c_row_end;
                    n_step  = '0;
                    n_sum   = '0;
                    n_state = wmar_pkg::BK_ACC;
                end
            end
            wmar_pkg::BK_ACC: begin
                n_rd_vld = 1'b1;
                n_step   = r_step + CW'(1);
                if (last_step) begin
                    n_state = wmar_pkg::BK_LAST;
                end
            end
            wmar_pkg::BK_LAST: begin
                n_state = wmar_pkg::BK_DIV;
            end
            wmar_pkg::BK_DIV: begin
                o_div_valid = 1'b1;
                if (i_div_ready) begin
                    if (last_out) begin
                        n_state = wmar_pkg::BK_IDLE;
                    end else begin
                        n_j     = r_j - NW'(1);
                        n_step  = '0;
                        n_sum   = '0;
                        n_state = wmar_pkg::BK_ACC;
                    end
                end
            end
            default: begin
                n_state = wmar_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= wmar_pkg::BK_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wp   <= n_wp;
        r_n    <= n_n;
        r_cnt  <= n_cnt;
        r_j    <= n_j;
        r_end  <= n_end;
        r_step <= n_step;
        r_sum  <= n_sum;
    end

endmodule

[hdl/weighted_moving_average_row.sv]
// Each result is paced by the one-read-a-cycle window walk and the bit-serial divider. The
//   front end keeps taking samples while the command queue has room, so the walk of the
//   next window can overlap the division of the last sum.
// Reset: synchronous, active low; clears the half width, row count, queue and all valids.
// ----------------------------------------------------------------------------
// weighted_moving_average_row
// Center-weighted moving average over rows of 16-bit samples, 8 fraction bits.
// ----------------------------------------------------------------------------
module weighted_moving_average_row #(
    parameter int MAX_HALF_WIDTH = 16,
    parameter int CMD_DEPTH      = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [wmar_pkg::HW_W-1:0]     i_cfg_half_width,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [wmar_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_row_end,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [wmar_pkg::SMOOTH_W-1:0] o_smoothed,
    output logic                          o_row_last,
    output logic                          o_run_last
);

    localparam int NW        = $clog2(MAX_HALF_WIDTH + 1);
    localparam int CW        = $clog2(2 * MAX_HALF_WIDTH + 2);
    localparam int SUM_W     = CW + wmar_pkg::SAMPLE_W;
    localparam int DVW       = $clog2(MAX_HALF_WIDTH + 2);
    localparam int RAM_AW    = $clog2(2 * MAX_HALF_WIDTH + CMD_DEPTH + 2);
    localparam int RAM_DEPTH = 2 ** RAM_AW;
    localparam int CMD_W     = 2 + RAM_AW + 2 * NW + CW;

    logic                          push_valid;
    logic                          push_ready;
    logic [CMD_W-1:0]              push_cmd;
    logic                          pop_valid;
    logic                          pop_ready;
    logic [CMD_W-1:0]              pop_cmd;
    logic                          we;
    logic [RAM_AW-1:0]             waddr;
    logic [wmar_pkg::SAMPLE_W-1:0] wdata;
    logic [RAM_AW-1:0]             raddr;
    logic [wmar_pkg::SAMPLE_W-1:0] rdata;
    logic                          div_valid;
    logic                          div_ready;
    logic [SUM_W-1:0]              div_sum;
    logic [DVW-1:0]                div_divisor;
    wmar_pkg::t_out_flags          div_flags;
    wmar_pkg::t_out_flags          out_flags;

    assign o_cfg_ready = 1'b1;
    assign o_row_last  = out_flags.row_last;
    assign o_run_last  = out_flags.run_last;

    wmar_ram #(
        .WIDTH (wmar_pkg::SAMPLE_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    wmar_front #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
        .RAM_AW         (RAM_AW)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_half_width (i_cfg_half_width),
        .i_valid          (i_valid),
        .i_sample         (i_sample),
        .i_row_end        (i_row_end),
        .o_ready          (o_ready),
        .i_push_ready     (push_ready),
        .o_push_valid     (push_valid),
        .o_cmd            (push_cmd),
        .o_we             (we),
        .o_waddr          (waddr),
        .o_wdata          (wdata)
    );

    wmar_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_data  (push_cmd),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_data   (pop_cmd),
        .i_pop_ready  (pop_ready)
    );

    wmar_back #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
        .RAM_AW         (RAM_AW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (pop_valid),
        .i_cmd       (pop_cmd),
        .o_cmd_pop   (pop_ready),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_div_valid (div_valid),
        .i_div_ready (div_ready),
        .o_sum       (div_sum),
        .o_divisor   (div_divisor),
        .o_flags     (div_flags)
    );

    wmar_div #(
        .SUM_W (SUM_W),
        .DVW   (DVW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (div_valid),
        .i_sum      (div_sum),
        .i_divisor  (div_divisor),
        .i_flags    (div_flags),
        .o_in_ready (div_ready),
        .o_valid    (o_valid),
        .o_smoothed (o_smoothed),
        .o_flags    (out_flags),
        .i_ready    (i_ready)
    );

endmodule

[hdl/wmar_checker.sv]
// ----------------------------------------------------------------------------
// wmar_checker
// Port-level checks on the row smoother, bound to the top level.
// ----------------------------------------------------------------------------
module wmar_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [wmar_pkg::SMOOTH_W-1:0] o_smoothed,
    input logic                          o_row_last,
    input logic                          o_run_last
);

    localparam logic [wmar_pkg::SMOOTH_W-1:0] MAX_AVG = 24'hFFFF00;

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_hold_stalled_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_smoothed)
            && $stable(o_row_last) && $stable(o_run_last))
        else $error("stalled output beat changed");

    a_row_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_row_last |-> o_run_last)
        else $error("row_last without run_last");

    a_average_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_smoothed <= MAX_AVG)
        else $error("average above largest sample");

endmodule

bind weighted_moving_average_row wmar_checker u_wmar_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_smoothed (o_smoothed),
    .o_row_last (o_row_last),
    .o_run_last (o_run_last)
);

[tb/weighted_moving_average_row_tb.sv]
// ----------------------------------------------------------------------------
// weighted_moving_average_row_tb
// Self-checking bench for the row smoother. A queue-fed driver sends sample
// beats with random gaps. A monitor predicts the center-weighted row averages
// owed by each accepted beat and compares each output beat, field by field,
// against the oldest owed result. The output side stalls at random. The half
// width is rewritten between phases, also in the middle of a row.
// ----------------------------------------------------------------------------
module weighted_moving_average_row_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_HW      = 16;
    localparam int WINDOW_LEN  = 2 * MAX_HW + 1;
    localparam int SETTLE_CYC  = 2 * MAX_HW + 100;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int MAX_WAIT    = 13;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_QUOTA = 18;

    typedef struct packed {
        logic [wmar_pkg::SAMPLE_W-1:0] sample;
        logic                          row_end;
    } t_sample_beat;

    typedef struct packed {
        logic [wmar_pkg::SMOOTH_W-1:0] smoothed;
        wmar_pkg::t_out_flags          flags;
    } t_smooth_beat;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [wmar_pkg::HW_W-1:0]     i_cfg_half_width;
    logic                          i_valid;
    logic                          o_ready;
    logic [wmar_pkg::SAMPLE_W-1:0] i_sample;
    logic                          i_row_end;
    logic                          o_valid;
    logic                          i_ready;
    logic [wmar_pkg::SMOOTH_W-1:0] o_smoothed;
    logic                          o_row_last;
    logic                          o_run_last;

    weighted_moving_average_row #(
        .MAX_HALF_WIDTH(MAX_HW)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_half_width(i_cfg_half_width),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample        (i_sample),
        .i_row_end       (i_row_end),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_smoothed      (o_smoothed),
        .o_row_last      (o_row_last),
        .o_run_last      (o_run_last)
    );

    t_sample_beat  sample_queue[$];
    t_smooth_beat  owed_results[$];

    logic [wmar_pkg::SAMPLE_W-1:0] row_window [0:WINDOW_LEN-1];
    int unsigned                   row_count;
    logic [wmar_pkg::HW_W-1:0]     cur_half_width;

    bit          tx_took;
    bit          rx_took;
    bit          tx_gaps_on;
    bit          rx_stalls_on;
    int unsigned gap_left;
    int unsigned stall_left;

    int unsigned cycles;
    int unsigned mismatches;
    int unsigned beats_sent;
    int unsigned results_seen;
    int unsigned rows_closed;
    int unsigned cfg_writes;

    always begin
        #5 i_clk = ~i_clk;
    end

    function automatic int unsigned draw_wait(bit on);
        return on ? $urandom_range(MAX_WAIT, 0) : 0;
    endfunction

    function automatic logic [wmar_pkg::SMOOTH_W-1:0] window_average(int j, int n, int count);
        logic [63:0] center;
        logic [63:0] sum;
        center = row_window[j];
        sum    = 2 * center;
        for (int k = 1; k <= n; k++) begin
            sum += (j + k < count) ? 64'(row_window[j + k]) : center;
            sum += (k <= j) ? 64'(row_window[j - k]) : center;
        end
        return wmar_pkg::SMOOTH_W'((sum << 8) / (2 * (n + 1)));
    endfunction

    function automatic void smooth_beat(logic [wmar_pkg::SAMPLE_W-1:0] smp, logic last);
        int           n;
        int           m;
        t_smooth_beat res;
        n = (cur_half_width > MAX_HW) ? MAX_HW : int'(cur_half_width);
        for (int i = WINDOW_LEN - 1; i > 0; i--) begin
            row_window[i] = row_window[i - 1];
        end
        row_window[0] = smp;
        if (row_count < WINDOW_LEN) begin
            row_count++;
        end
        if (!last) begin
            if (row_count > n) begin
                res.smoothed       = window_average(n, n, row_count);
                res.flags.row_last = 1'b0;
                res.flags.run_last = 1'b1;
                owed_results.push_back(res);
            end
        end else begin
            m = (row_count < n + 1) ? row_count : n + 1;
            for (int r = 0; r < m; r++) begin
                res.smoothed       = window_average(m - 1 - r, n, row_count);
                res.flags.row_last = (r == m - 1);
                res.flags.run_last = (r == m - 1);
                owed_results.push_back(res);
            end
            row_count = 0;
            rows_closed++;
        end
    endfunction

    task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0t] %s mismatch: expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_smooth_beat want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[%0t] timeout after %0d cycles, %0d results owed", $time, cycles,
                     owed_results.size());
            $display("weighted_moving_average_row_tb failed");
            $finish;
        end else if (i_rst_n) begin
            tx_took = i_valid && o_ready;
            if (tx_took) begin
                smooth_beat(i_sample, i_row_end);
                beats_sent++;
            end
            rx_took = o_valid && i_ready;
            if (rx_took) begin
                results_seen++;
                if (owed_results.size() == 0) begin
                    note_mismatch("unowed result", 32'h0, 32'(o_smoothed));
                end else begin
                    want = owed_results.pop_front();
                    if (o_smoothed !== want.smoothed) begin
                        note_mismatch("smoothed", 32'(want.smoothed), 32'(o_smoothed));
                    end
                    if (o_row_last !== want.flags.row_last) begin
                        note_mismatch("row_last", 32'(want.flags.row_last), 32'(o_row_last));
                    end
                    if (o_run_last !== want.flags.run_last) begin
                        note_mismatch("run_last", 32'(want.flags.run_last), 32'(o_run_last));
                    end
                end
            end
        end
    end

    // sample driver: hold until accepted, then gap, then next beat
    always @(negedge i_clk) begin
        t_sample_beat beat;
        if (!i_valid || tx_took) begin
            if (gap_left > 0) begin
                i_valid <= 1'b0;
                gap_left--;
            end else if (sample_queue.size() > 0) begin
                beat = sample_queue.pop_front();
                i_valid   <= 1'b1;
                i_sample  <= beat.sample;
                i_row_end <= beat.row_end;
                gap_left  = draw_wait(tx_gaps_on);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result sink: random stall after each beat
    always @(negedge i_clk) begin
        if (rx_took) begin
            stall_left = draw_wait(rx_stalls_on);
        end
        if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left--;
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic push_sample(logic [wmar_pkg::SAMPLE_W-1:0] smp, logic last);
        t_sample_beat beat;
        beat.sample  = smp;
        beat.row_end = last;
        sample_queue.push_back(beat);
    endtask

    task automatic wait_idle();
        while (sample_queue.size() != 0 || i_valid || owed_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_half_width(logic [wmar_pkg::HW_W-1:0] value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid      <= 1'b1;
        i_cfg_half_width <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        cur_half_width = value;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [wmar_pkg::SAMPLE_W-1:0] pick_sample();
        int unsigned sel;
        sel = $urandom_range(7, 0);
        if (sel == 0) begin
            return '0;
        end else if (sel == 1) begin
            return '1;
        end
        return wmar_pkg::SAMPLE_W'($urandom_range(16'hFFFF, 0));
    endfunction

    task automatic make_rows(int quota, int n, bit open_end);
        int left;
        int len;
        int sel;
        left = quota;
        while (left > 0) begin
            sel = $urandom_range(9, 0);
            if (sel <= 6) begin
                len = $urandom_range(2 * n + 4, 1);
            end else if (sel == 7) begin
                len = $urandom_range(45, 30);
            end else if (sel == 8) begin
                len = 1;
            end else begin
                len = $urandom_range(4, 2);
            end
            for (int i = 0; i < len; i++) begin
                push_sample(pick_sample(), i == len - 1);
            end
            left -= len;
        end
        if (open_end) begin
            len = $urandom_range(3, 1);
            for (int i = 0; i < len; i++) begin
                push_sample(pick_sample(), 1'b0);
            end
        end
    endtask

    initial begin
        logic [wmar_pkg::HW_W-1:0] phase_hw [RAND_PHASES];
        int                        n_eff;
        phase_hw = '{5'd1, 5'd16, 5'd0, 5'd5, 5'd31, 5'd2, 5'd17, 5'd8, 5'd0, 5'd0};
        phase_hw[8] = wmar_pkg::HW_W'($urandom_range(31, 0));
        phase_hw[9] = wmar_pkg::HW_W'($urandom_range(31, 0));

        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_half_width = '0;
        i_valid          = 1'b0;
        i_sample         = '0;
        i_row_end        = 1'b0;
        i_ready          = 1'b0;
        tx_took          = 1'b0;
        rx_took          = 1'b0;
        tx_gaps_on       = 1'b1;
        rx_stalls_on     = 1'b1;
        gap_left         = 0;
        stall_left       = 0;
        cycles           = 0;
        mismatches       = 0;
        beats_sent       = 0;
        results_seen     = 0;
        rows_closed      = 0;
        cfg_writes       = 0;
        row_count        = 0;
        cur_half_width   = '0;
        for (int i = 0; i < WINDOW_LEN; i++) begin
            row_window[i] = '0;
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset half width: every sample is its own average
        push_sample(16'h0000, 1'b0);
        push_sample(16'hFFFF, 1'b1);
        push_sample(16'h1234, 1'b1);

        write_half_width(5'd2);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'h0000, 1'b0);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'h0000, 1'b0);
        push_sample(16'hFFFF, 1'b1);
        push_sample(16'h00FF, 1'b1);
        push_sample(16'hFF00, 1'b0);
        push_sample(16'h8001, 1'b1);

        // above the maximum: clamps to the widest window
        write_half_width(5'd31);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'hFFFF, 1'b1);
        push_sample(16'h5555, 1'b0);
        push_sample(16'hAAAA, 1'b1);

        // change the half width in the middle of a row
        write_half_width(5'd3);
        push_sample(16'h0007, 1'b0);
        push_sample(16'h0009, 1'b0);
        write_half_width(5'd1);
        push_sample(16'h000B, 1'b0);
        push_sample(16'h000D, 1'b1);

        for (int p = 0; p < RAND_PHASES; p++) begin
            write_half_width(phase_hw[p]);
            tx_gaps_on   = ($urandom_range(3, 0) != 0);
            rx_stalls_on = ($urandom_range(3, 0) != 0);
            n_eff = (phase_hw[p] > MAX_HW) ? MAX_HW : int'(phase_hw[p]);
            make_rows(PHASE_QUOTA, n_eff, $urandom_range(2, 0) == 0);
        end

        wait_idle();
        $display("sent %0d sample beats in %0d closed rows, checked %0d results",
                 beats_sent, rows_closed, results_seen);
        $display("half width written %0d times, %0d mismatches", cfg_writes, mismatches);
        if (mismatches == 0 && owed_results.size() == 0) begin
            $display("weighted_moving_average_row_tb passed");
        end else begin
            $display("weighted_moving_average_row_tb failed");
        end
        $finish;
    end

endmodule
